@@ src/abg_pkg.sv @@
`timescale 1ns / 1ps
package abg_pkg;
	localparam int FRAC_BITS_DEF = 8;
	localparam int BASE_W = 11;
	localparam int IN_W = 16;
	localparam int COORD_W = 32;
	localparam logic [BASE_W-1:0] BASE_RESET = 11'd16;
endpackage

@@ src/abg_if.sv @@
`timescale 1ns / 1ps
interface abg_in_if;
	logic                         valid;
	logic                         ready;
	logic [abg_pkg::IN_W-1:0]     ratio;
	logic [abg_pkg::IN_W-1:0]     scale;
	modport source (output valid, ratio, scale, input ready);
	modport sink (input valid, ratio, scale, output ready);
endinterface

interface abg_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [abg_pkg::COORD_W-1:0] start_x;
	logic signed [abg_pkg::COORD_W-1:0] start_y;
	logic signed [abg_pkg::COORD_W-1:0] end_x;
	logic signed [abg_pkg::COORD_W-1:0] end_y;
	logic                               invalid;
	modport source (output valid, start_x, start_y, end_x, end_y, invalid, input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, invalid, output ready);
endinterface

@@ src/abg_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per stage: q = (4*b*b << F) / ratio.
module abg_div #(
	parameter int FRAC_BITS = abg_pkg::FRAC_BITS_DEF,
	parameter int NUM_W = 24 + FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         up_valid,
	output logic                         up_ready,
	input  logic [abg_pkg::IN_W-1:0]     up_ratio,
	input  logic [abg_pkg::IN_W-1:0]     up_scale,
	input  logic [abg_pkg::BASE_W-1:0]   up_base,
	output logic                         dn_valid,
	input  logic                         dn_ready,
	output logic [NUM_W-1:0]             dn_quot,
	output logic [abg_pkg::IN_W-1:0]     dn_ratio,
	output logic [abg_pkg::IN_W-1:0]     dn_scale,
	output logic [abg_pkg::BASE_W-1:0]   dn_base
);
	localparam int W = abg_pkg::IN_W;
	localparam int D = NUM_W + 1;

	logic [D-1:0]               v_s1;
	logic [D-1:0]               en;
	logic [W-1:0]               rem_s1 [D];
	logic [NUM_W-1:0]           nq_s1 [D];
	logic [W-1:0]               r_s1 [D];
	logic [W-1:0]               s_s1 [D];
	logic [abg_pkg::BASE_W-1:0] b_s1 [D];
	logic [2*abg_pkg::BASE_W-1:0] sq;

	assign sq = up_base * up_base;

	// bubble-collapsing enables: a stage moves if empty or its successor moves
	assign en[D-1] = !v_s1[D-1] || dn_ready;
	for (genvar k = 0; k < D-1; k++) begin : g_en
		assign en[k] = !v_s1[k] || en[k+1];
	end
	assign up_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1[0] <= 1'b0;
		end else if (en[0]) begin
			v_s1[0] <= up_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s1[0] <= '0;
			nq_s1[0]  <= {sq, 2'b00, {FRAC_BITS{1'b0}}};
			r_s1[0]   <= up_ratio;
			s_s1[0]   <= up_scale;
			b_s1[0]   <= up_base;
		end
	end

	for (genvar k = 1; k < D; k++) begin : g_st
		logic [W:0] t;
		logic       qb;
		assign t  = {rem_s1[k-1], nq_s1[k-1][NUM_W-1]};
		assign qb = t >= {1'b0, r_s1[k-1]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1[k] <= 1'b0;
			end else if (en[k]) begin
				v_s1[k] <= v_s1[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s1[k] <= qb ? W'(t - {1'b0, r_s1[k-1]}) : t[W-1:0];
				nq_s1[k]  <= {nq_s1[k-1][NUM_W-2:0], qb};
				r_s1[k]   <= r_s1[k-1];
				s_s1[k]   <= s_s1[k-1];
				b_s1[k]   <= b_s1[k-1];
			end
		end
	end

	assign dn_valid = v_s1[D-1];
	assign dn_quot  = nq_s1[D-1];
	assign dn_ratio = r_s1[D-1];
	assign dn_scale = s_s1[D-1];
	assign dn_base  = b_s1[D-1];
endmodule

@@ src/abg_sqrt.sv @@
`timescale 1ns / 1ps
// Digit-by-digit integer square root, one root bit per stage.
module abg_sqrt #(
	parameter int NUM_W = 32,
	parameter int SQ_W = (NUM_W + 1) / 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         up_valid,
	output logic                         up_ready,
	input  logic [NUM_W-1:0]             up_quot,
	input  logic [abg_pkg::IN_W-1:0]     up_ratio,
	input  logic [abg_pkg::IN_W-1:0]     up_scale,
	input  logic [abg_pkg::BASE_W-1:0]   up_base,
	output logic                         dn_valid,
	input  logic                         dn_ready,
	output logic [SQ_W-1:0]              dn_root,
	output logic [abg_pkg::IN_W-1:0]     dn_ratio,
	output logic [abg_pkg::IN_W-1:0]     dn_scale,
	output logic [abg_pkg::BASE_W-1:0]   dn_base
);
	localparam int W = abg_pkg::IN_W;
	localparam int D = SQ_W + 1;
	localparam int RW = SQ_W + 2;
	localparam int XW = 2 * SQ_W;

	logic [D-1:0]               v_s1;
	logic [D-1:0]               en;
	logic [RW-1:0]              rem_s1 [D];
	logic [SQ_W-1:0]            root_s1 [D];
	logic [XW-1:0]              x_s1 [D];
	logic [W-1:0]               r_s1 [D];
	logic [W-1:0]               s_s1 [D];
	logic [abg_pkg::BASE_W-1:0] b_s1 [D];

	assign en[D-1] = !v_s1[D-1] || dn_ready;
	for (genvar k = 0; k < D-1; k++) begin : g_en
		assign en[k] = !v_s1[k] || en[k+1];
	end
	assign up_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1[0] <= 1'b0;
		end else if (en[0]) begin
			v_s1[0] <= up_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s1[0]  <= '0;
			root_s1[0] <= '0;
			x_s1[0]    <= XW'(up_quot);
			r_s1[0]    <= up_ratio;
			s_s1[0]    <= up_scale;
			b_s1[0]    <= up_base;
		end
	end

	for (genvar k = 1; k < D; k++) begin : g_st
		logic [RW+1:0] t;
		logic [RW+1:0] trial;
		logic          ge;
		assign t     = {rem_s1[k-1], x_s1[k-1][XW-1 -: 2]};
		assign trial = (RW+2)'({root_s1[k-1], 2'b01});
		assign ge    = t >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1[k] <= 1'b0;
			end else if (en[k]) begin
				v_s1[k] <= v_s1[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s1[k]  <= ge ? RW'(t - trial) : t[RW-1:0];
				root_s1[k] <= {root_s1[k-1][SQ_W-2:0], ge};
				x_s1[k]    <= {x_s1[k-1][XW-3:0], 2'b00};
				r_s1[k]    <= r_s1[k-1];
				s_s1[k]    <= s_s1[k-1];
				b_s1[k]    <= b_s1[k-1];
			end
		end
	end

	assign dn_valid = v_s1[D-1];
	assign dn_root  = root_s1[D-1];
	assign dn_ratio = r_s1[D-1];
	assign dn_scale = s_s1[D-1];
	assign dn_base  = b_s1[D-1];
endmodule

@@ src/abg_box.sv @@
`timescale 1ns / 1ps
// Width/height rounding, scaling and corner placement with saturation.
module abg_box #(
	parameter int FRAC_BITS = abg_pkg::FRAC_BITS_DEF,
	parameter int SQ_W = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               up_valid,
	output logic                               up_ready,
	input  logic [SQ_W-1:0]                    up_root,
	input  logic [abg_pkg::IN_W-1:0]           up_ratio,
	input  logic [abg_pkg::IN_W-1:0]           up_scale,
	input  logic [abg_pkg::BASE_W-1:0]         up_base,
	output logic                               dn_valid,
	input  logic                               dn_ready,
	output logic signed [abg_pkg::COORD_W-1:0] dn_sx,
	output logic signed [abg_pkg::COORD_W-1:0] dn_sy,
	output logic signed [abg_pkg::COORD_W-1:0] dn_ex,
	output logic signed [abg_pkg::COORD_W-1:0] dn_ey,
	output logic                               dn_inv
);
	localparam int W = abg_pkg::IN_W;
	localparam int CO = abg_pkg::COORD_W;
	localparam int HS_W = SQ_W + W - FRAC_BITS;
	localparam int PW_W = SQ_W + W;
	localparam int PH_W = HS_W + W;
	localparam int CW = PH_W + 3;
	localparam logic signed [CW-1:0] MAXV = {{(CW-CO){1'b0}}, 1'b0, {(CO-1){1'b1}}};
	localparam logic signed [CW-1:0] MINV = {{(CW-CO){1'b1}}, 1'b1, {(CO-1){1'b0}}};

	function automatic logic signed [CO-1:0] rnd_sat(input logic signed [CW-1:0] x);
		logic signed [CW-1:0] h;
		h = (x + CW'(1)) >>> 1;
		if (h > MAXV) begin
			return MAXV[CO-1:0];
		end else if (h < MINV) begin
			return MINV[CO-1:0];
		end
		return h[CO-1:0];
	endfunction

	logic [3:0] v_s;
	logic [3:0] en;

	logic [SQ_W-1:0]            ws_s1;
	logic [W-1:0]               r_s1, s_s1;
	logic [abg_pkg::BASE_W-1:0] b_s1, b_s2, b_s3;
	logic                       inv_s1, inv_s2, inv_s3;
	logic [SQ_W:0]              root_inc;
	logic [PW_W-1:0]            wr;

	logic [HS_W-1:0]            hs_s2;
	logic [PW_W-1:0]            pw_s2, pw_s3;
	logic [W-1:0]               s_s2;
	logic [PH_W-1:0]            ph_s3;

	logic signed [CW-1:0]       bias, two, sxr, syr, exr, eyr;

	assign en[3] = !v_s[3] || dn_ready;
	for (genvar k = 0; k < 3; k++) begin : g_en
		assign en[k] = !v_s[k] || en[k+1];
	end
	assign up_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[0]) v_s[0] <= up_valid;
			if (en[1]) v_s[1] <= v_s[0];
			if (en[2]) v_s[2] <= v_s[1];
			if (en[3]) v_s[3] <= v_s[2];
		end
	end

	// ws = (root + 1) / 2
	assign root_inc = {1'b0, up_root} + (SQ_W+1)'(1);
	assign wr = ws_s1 * r_s1;

	assign bias = CW'(b_s3) <<< FRAC_BITS;
	assign two  = CW'(2) <<< FRAC_BITS;
	assign sxr  = bias - CW'(pw_s3);
	assign syr  = bias - CW'(ph_s3);
	assign exr  = bias - two + CW'(pw_s3);
	assign eyr  = bias - two + CW'(ph_s3);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ws_s1  <= root_inc[SQ_W:1];
			r_s1   <= up_ratio;
			s_s1   <= up_scale;
			b_s1   <= up_base;
			inv_s1 <= up_ratio == '0;
		end
		if (en[1]) begin
			hs_s2  <= HS_W'((wr + PW_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
			pw_s2  <= ws_s1 * s_s1;
			s_s2   <= s_s1;
			b_s2   <= b_s1;
			inv_s2 <= inv_s1;
		end
		if (en[2]) begin
			ph_s3  <= hs_s2 * s_s2;
			pw_s3  <= pw_s2;
			b_s3   <= b_s2;
			inv_s3 <= inv_s2;
		end
		if (en[3]) begin
			dn_sx  <= inv_s3 ? '0 : rnd_sat(sxr);
			dn_sy  <= inv_s3 ? '0 : rnd_sat(syr);
			dn_ex  <= inv_s3 ? '0 : rnd_sat(exr);
			dn_ey  <= inv_s3 ? '0 : rnd_sat(eyr);
			dn_inv <= inv_s3;
		end
	end

	assign dn_valid = v_s[3];
endmodule

@@ src/anchor_box_generator_core.sv @@
`timescale 1ns / 1ps
// Anchor box generator: each input transaction (ratio, scale, both unsigned Q.F) yields one
// output transaction with the box corners in signed Q.F, saturated to 32 bits, and invalid
// set (coordinates zero) when ratio is zero. Fully pipelined through (24 + FRAC_BITS) + 1
// divider stages, ceil((24 + FRAC_BITS) / 2) + 1 square root stages and 4 box stages: one
// transaction per cycle unless the output stalls. A stage stalls only when full and its
// successor stalls, so bubbles collapse and input keeps flowing while a result waits, until
// every stage holds a transaction. The anchor side length resets to 16; the user must write
// it via cfg_we/cfg_wdata only while no transaction is in flight, which is not enforced.
module anchor_box_generator_core #(
	parameter int FRAC_BITS = abg_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [abg_pkg::BASE_W-1:0]   cfg_wdata,
	abg_in_if.sink                       in_ch,
	abg_out_if.source                    out_ch
);
	// numerator 4*b*b << F and its root widths
	localparam int NUM_W = 24 + FRAC_BITS;
	localparam int SQ_W = (NUM_W + 1) / 2;

	logic [abg_pkg::BASE_W-1:0] base_q;

	// divider -> square root
	logic                       d_valid, d_ready;
	logic [NUM_W-1:0]           d_quot;
	logic [abg_pkg::IN_W-1:0]   d_ratio, d_scale;
	logic [abg_pkg::BASE_W-1:0] d_base;

	// square root -> box
	logic                       q_valid, q_ready;
	logic [SQ_W-1:0]            q_root;
	logic [abg_pkg::IN_W-1:0]   q_ratio, q_scale;
	logic [abg_pkg::BASE_W-1:0] q_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= abg_pkg::BASE_RESET;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	abg_div #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (in_ch.valid),
		.up_ready (in_ch.ready),
		.up_ratio (in_ch.ratio),
		.up_scale (in_ch.scale),
		.up_base  (base_q),
		.dn_valid (d_valid),
		.dn_ready (d_ready),
		.dn_quot  (d_quot),
		.dn_ratio (d_ratio),
		.dn_scale (d_scale),
		.dn_base  (d_base)
	);

	abg_sqrt #(.NUM_W(NUM_W), .SQ_W(SQ_W)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (d_valid),
		.up_ready (d_ready),
		.up_quot  (d_quot),
		.up_ratio (d_ratio),
		.up_scale (d_scale),
		.up_base  (d_base),
		.dn_valid (q_valid),
		.dn_ready (q_ready),
		.dn_root  (q_root),
		.dn_ratio (q_ratio),
		.dn_scale (q_scale),
		.dn_base  (q_base)
	);

	// final stage register doubles as the output register
	abg_box #(.FRAC_BITS(FRAC_BITS), .SQ_W(SQ_W)) u_box (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (q_valid),
		.up_ready (q_ready),
		.up_root  (q_root),
		.up_ratio (q_ratio),
		.up_scale (q_scale),
		.up_base  (q_base),
		.dn_valid (out_ch.valid),
		.dn_ready (out_ch.ready),
		.dn_sx    (out_ch.start_x),
		.dn_sy    (out_ch.start_y),
		.dn_ex    (out_ch.end_x),
		.dn_ey    (out_ch.end_y),
		.dn_inv   (out_ch.invalid)
	);
endmodule

@@ src/abg_checker.sv @@
`timescale 1ns / 1ps
module abg_checker #(
	parameter int FRAC_BITS = abg_pkg::FRAC_BITS_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [abg_pkg::COORD_W-1:0] start_x,
	input logic signed [abg_pkg::COORD_W-1:0] start_y,
	input logic signed [abg_pkg::COORD_W-1:0] end_x,
	input logic signed [abg_pkg::COORD_W-1:0] end_y,
	input logic                               invalid
);
	localparam int CO = abg_pkg::COORD_W;

	// invalid transactions carry zero corners
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid |-> start_x == '0 && start_y == '0 && end_x == '0 && end_y == '0)
		else $error("invalid box with non-zero corners");

	// a box is never narrower than minus one pixel
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !invalid |->
			(CO+1)'(end_x) + (CO+1)'(1 << FRAC_BITS) >= (CO+1)'(start_x) &&
			(CO+1)'(end_y) + (CO+1)'(1 << FRAC_BITS) >= (CO+1)'(start_y))
		else $error("box corners out of order");

	// with the output empty the pipeline cannot be blocking input
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// stalled result holds: valid, start_x, end_y and invalid stay stable
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(start_x) && $stable(end_y)
			&& $stable(invalid))
		else $error("stalled transaction changed");
endmodule

bind anchor_box_generator_core abg_checker #(.FRAC_BITS(FRAC_BITS)) u_abg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.start_x   (out_ch.start_x),
	.start_y   (out_ch.start_y),
	.end_x     (out_ch.end_x),
	.end_y     (out_ch.end_y),
	.invalid   (out_ch.invalid)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Anchor box generator testbench.
// A directed pass covers zero ratio, the field extremes, zero scale and the
// anchor side extremes. Random phases follow, each with its own anchor side.
// A local predictor works out every box as its input transaction is accepted.
// One monitor compares each output transaction with the oldest queued box.
// Both sides idle in random bursts, and the final phase runs with no idling.
module testbench;
	typedef struct packed {
		logic signed [abg_pkg::COORD_W-1:0] sx;
		logic signed [abg_pkg::COORD_W-1:0] sy;
		logic signed [abg_pkg::COORD_W-1:0] ex;
		logic signed [abg_pkg::COORD_W-1:0] ey;
		logic                               inv;
	} box_t;

	localparam int FB = abg_pkg::FRAC_BITS_DEF;
	localparam int DRAIN_CYCLES = 64;	// pipeline is 54 deep at the default width

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [abg_pkg::BASE_W-1:0] cfg_wdata;

	abg_in_if in_if();
	abg_out_if out_if();

	anchor_box_generator_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_if),
		.out_ch(out_if)
	);

	box_t boxes_pending[$];
	logic [abg_pkg::BASE_W-1:0] base_now;
	bit idle_on;
	int errors;
	int stall_left;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// floor((v + 1) / 2)
	function automatic longint round_half(input longint v);
		return (v + 1) >>> 1;
	endfunction

	function automatic logic signed [abg_pkg::COORD_W-1:0] clamp32(input longint v);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[abg_pkg::COORD_W-1:0];
	endfunction

	function automatic box_t anchor_box(input logic [abg_pkg::IN_W-1:0] ratio,
			input logic [abg_pkg::IN_W-1:0] scale, input logic [abg_pkg::BASE_W-1:0] base);
		box_t bx;
		longint unsigned r, s, b, q, ws, hs;
		longint bias;
		r = ratio;
		s = scale;
		b = base;
		bx = '0;
		if (r == 0) begin
			bx.inv = 1'b1;
			return bx;
		end
		q = ((4 * b * b) << FB) / r;
		ws = (int_sqrt(q) + 1) >> 1;
		hs = (ws * r + (64'd1 << (FB - 1))) >> FB;
		bias = longint'(b << FB);
		bx.sx = clamp32(round_half(bias - longint'(ws * s)));
		bx.sy = clamp32(round_half(bias - longint'(hs * s)));
		bx.ex = clamp32(round_half(bias - (64'sd2 << FB) + longint'(ws * s)));
		bx.ey = clamp32(round_half(bias - (64'sd2 << FB) + longint'(hs * s)));
		return bx;
	endfunction

	// one input transaction; valid is left high so back-to-back items never toggle it
	task automatic send_anchor(input logic [abg_pkg::IN_W-1:0] ratio,
			input logic [abg_pkg::IN_W-1:0] scale);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = int'($urandom_range(1, 13));
			in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.ratio <= ratio;
		in_if.scale <= scale;
		@(posedge clk);
		while (!in_if.ready) @(posedge clk);
		boxes_pending.push_back(anchor_box(ratio, scale, base_now));
	endtask

	// the anchor side only changes once the pipeline has drained
	task automatic set_base(input logic [abg_pkg::BASE_W-1:0] value);
		in_if.valid <= 1'b0;
		@(posedge clk);
		while (boxes_pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		base_now = value;
	endtask

	task automatic test_directed();
		send_anchor(16'h0000, 16'h0100);	// zero ratio
		send_anchor(16'h0000, 16'hFFFF);
		send_anchor(16'h0100, 16'h0100);
		send_anchor(16'h0080, 16'h0800);
		send_anchor(16'h0200, 16'h0800);
		send_anchor(16'h0100, 16'h0000);	// zero scale
		send_anchor(16'h0001, 16'hFFFF);
		send_anchor(16'hFFFF, 16'hFFFF);
		send_anchor(16'hFFFF, 16'h0001);
		send_anchor(16'h0180, 16'h1000);
		set_base(11'd1);
		send_anchor(16'h0100, 16'h0100);
		send_anchor(16'h0001, 16'hFFFF);
		send_anchor(16'hFFFF, 16'h0000);
		send_anchor(16'h0000, 16'h0000);
		set_base(11'd1024);
		send_anchor(16'h0001, 16'hFFFF);
		send_anchor(16'h0100, 16'hFFFF);
		send_anchor(16'hFFFF, 16'hFFFF);
		send_anchor(16'h0040, 16'h2000);
		set_base(11'd1023);
		send_anchor(16'h5555, 16'hAAAA);
		send_anchor(16'hAAAA, 16'h5555);
		send_anchor(16'h0100, 16'h0100);
	endtask

	task automatic test_random_phase(input logic [abg_pkg::BASE_W-1:0] base, input int count);
		int i, j, k, sel;
		logic [abg_pkg::IN_W-1:0] r, s;
		set_base(base);
		i = 0;
		while (i < count) begin
			sel = int'($urandom_range(0, 9));
			if (sel < 7) begin
				// ratio-major, scale-minor grid as a sender would supply it
				for (j = 0; j < 3 && i < count; j++) begin
					r = abg_pkg::IN_W'($urandom_range(16'h0020, 16'h0800));
					for (k = 0; k < 3 && i < count; k++) begin
						s = abg_pkg::IN_W'($urandom_range(16'h0010, 16'h4000));
						send_anchor(r, s);
						i++;
					end
				end
			end else if (sel < 9) begin
				send_anchor(abg_pkg::IN_W'($urandom()), abg_pkg::IN_W'($urandom()));
				i++;
			end else begin
				send_anchor(16'h0000, abg_pkg::IN_W'($urandom()));
				i++;
			end
		end
	endtask

	// receiver: ready drops in random bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_if.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= int'($urandom_range(0, 12));
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= 1'b1;
		end
	end

	// compare each output transaction with the oldest predicted box
	always @(posedge clk) begin
		box_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (boxes_pending.size() == 0) begin
				$display("%0t: unexpected box sx=%0d sy=%0d ex=%0d ey=%0d inv=%0b", $time,
					out_if.start_x, out_if.start_y, out_if.end_x, out_if.end_y,
					out_if.invalid);
				errors++;
			end else begin
				want = boxes_pending.pop_front();
				if (out_if.start_x !== want.sx) begin
					$display("%0t: start_x expected %0d actual %0d", $time, want.sx,
						out_if.start_x);
					errors++;
				end
				if (out_if.start_y !== want.sy) begin
					$display("%0t: start_y expected %0d actual %0d", $time, want.sy,
						out_if.start_y);
					errors++;
				end
				if (out_if.end_x !== want.ex) begin
					$display("%0t: end_x expected %0d actual %0d", $time, want.ex,
						out_if.end_x);
					errors++;
				end
				if (out_if.end_y !== want.ey) begin
					$display("%0t: end_y expected %0d actual %0d", $time, want.ey,
						out_if.end_y);
					errors++;
				end
				if (out_if.invalid !== want.inv) begin
					$display("%0t: invalid expected %0b actual %0b", $time, want.inv,
						out_if.invalid);
					errors++;
				end
			end
		end
	end

	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		errors = 0;
		idle_on = 1'b1;
		base_now = abg_pkg::BASE_RESET;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_if.valid <= 1'b0;
		in_if.ratio <= '0;
		in_if.scale <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phase(11'd16, 250);
		test_random_phase(11'd1, 150);
		test_random_phase(11'd1024, 150);
		test_random_phase(abg_pkg::BASE_W'($urandom_range(1, 1024)), 250);
		test_random_phase(abg_pkg::BASE_W'($urandom_range(1, 1024)), 200);
		idle_on = 1'b0;
		test_random_phase(11'd600, 200);
		in_if.valid <= 1'b0;
		@(posedge clk);
		while (boxes_pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
